@@ hw/rtl/mm_pkg.sv @@
// shared types, constants and helpers for the matrix multiply core
package mm_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_W   = $clog2(DIM_CAP);
  localparam int FIELD_W = 3;
  localparam int DIM_W   = 4;
  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = PROD_W + $clog2(DIM_CAP);
  localparam int FRAC_W  = 16;
  localparam int RND_W   = ACC_W - FRAC_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  localparam logic [1:0] MODE_WR_A    = 2'd0;
  localparam logic [1:0] MODE_WR_B    = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last_k;
    logic               last_elem;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
  } mm_tag_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > DIM_CAP) r = DIM_W'(DIM_CAP);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mm_addr(input logic [FIELD_W-1:0] r,
                                                input logic [FIELD_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

@@ hw/rtl/mm_store.sv @@
// element memories for matrices a and b, one write and one registered read each
module mm_store (
  input  logic                      clk,
  input  logic                      wr_a,
  input  logic                      wr_b,
  input  logic [mm_pkg::ADDR_W-1:0] wr_addr,
  input  logic [mm_pkg::ELEM_W-1:0] wr_data,
  input  logic [mm_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [mm_pkg::ADDR_W-1:0] rd_addr_b,
  output logic [mm_pkg::ELEM_W-1:0] rd_data_a,
  output logic [mm_pkg::ELEM_W-1:0] rd_data_b
);
  import mm_pkg::*;

  logic [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    rd_data_a <= a_mem[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    rd_data_b <= b_mem[rd_addr_b];
  end

endmodule

@@ hw/rtl/mm_seq.sv @@
// index sequencer walking i, j, k and issuing memory reads
module mm_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [mm_pkg::DIM_W-1:0]  rows_a,
  input  logic [mm_pkg::DIM_W-1:0]  inner_dim,
  input  logic [mm_pkg::DIM_W-1:0]  cols_b,
  output logic [mm_pkg::ADDR_W-1:0] rd_addr_a,
  output logic [mm_pkg::ADDR_W-1:0] rd_addr_b,
  output mm_pkg::mm_tag_t           tag,
  output logic                      running
);
  import mm_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] nr, nk, nc;
  logic             last_i, last_j, last_k;

  assign nr = eff_dim(rows_a);
  assign nk = eff_dim(inner_dim);
  assign nc = eff_dim(cols_b);

  assign last_i = (DIM_W'(i_r) + DIM_W'(1)) == nr;
  assign last_j = (DIM_W'(j_r) + DIM_W'(1)) == nc;
  assign last_k = (DIM_W'(k_r) + DIM_W'(1)) == nk;

  assign rd_addr_a = mm_addr(FIELD_W'(i_r), FIELD_W'(k_r));
  assign rd_addr_b = mm_addr(FIELD_W'(k_r), FIELD_W'(j_r));
  assign running   = (state_r == SEQ_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    tag.valid     = 1'b0;
    tag.first     = (k_r == '0);
    tag.last_k    = last_k;
    tag.last_elem = last_k && last_j && last_i;
    tag.row       = FIELD_W'(i_r);
    tag.col       = FIELD_W'(j_r);
    unique case (state_r)
      SEQ_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (go) begin
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        tag.valid = 1'b1;
        k_nxt = k_r + CNT_W'(1);
        if (last_k) begin
          k_nxt = '0;
          j_nxt = j_r + CNT_W'(1);
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + CNT_W'(1);
            if (last_i) begin
              state_nxt = SEQ_IDLE;
            end
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/mm_mac.sv @@
// multiply, accumulate, round and saturate pipeline with output register
module mm_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mm_pkg::mm_tag_t            tag,
  input  logic [mm_pkg::ELEM_W-1:0]  a_data,
  input  logic [mm_pkg::ELEM_W-1:0]  b_data,
  output logic                       pipe_busy,
  output logic                       out_valid,
  output logic [mm_pkg::FIELD_W-1:0] out_row,
  output logic [mm_pkg::FIELD_W-1:0] out_col,
  output logic [mm_pkg::ELEM_W-1:0]  out_sum,
  output logic                       out_last
);
  import mm_pkg::*;

  mm_tag_t                   tag1_r, tag2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_rnd;
  logic                      v3_r, v4_r, vo_r;
  logic [FIELD_W-1:0]        row3_r, col3_r, row4_r, col4_r;
  logic                      last3_r, last4_r;
  logic [RND_W-1:0]          rnd_r;
  logic [ELEM_W-1:0]         sum_nxt;
  logic [RND_W-ELEM_W:0]     hi_bits;

  assign acc_nxt = tag2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  assign acc_rnd = acc_r + RND_HALF;
  assign hi_bits = rnd_r[RND_W-1:ELEM_W-1];

  always_comb begin
    sum_nxt = rnd_r[ELEM_W-1:0];
    if (!(&hi_bits) && (|hi_bits)) begin
      sum_nxt = rnd_r[RND_W-1] ? SAT_NEG : SAT_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      vo_r   <= 1'b0;
    end else begin
      tag1_r <= tag;
      tag2_r <= tag1_r;
      v3_r   <= tag2_r.valid && tag2_r.last_k;
      v4_r   <= v3_r;
      vo_r   <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= $signed(a_data) * $signed(b_data);
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
    row3_r  <= tag2_r.row;
    col3_r  <= tag2_r.col;
    last3_r <= tag2_r.last_elem;
    rnd_r   <= acc_rnd[ACC_W-1:FRAC_W];
    row4_r  <= row3_r;
    col4_r  <= col3_r;
    last4_r <= last3_r;
    out_row <= row4_r;
    out_col <= col4_r;
    out_sum <= sum_nxt;
    out_last <= last4_r;
  end

  assign out_valid = vo_r;
  assign pipe_busy = tag1_r.valid || tag2_r.valid || v3_r || v4_r;

endmodule

@@ hw/rtl/matrix_multiply_core.sv @@
// matrix multiply core top level: config registers, word decode and assertions
//
// channel  ports                                       handshake
// -------  ------------------------------------------  ---------------------------
// input    in_mode in_row in_col in_element            start && !busy
// result   out_row out_col out_sum out_last            out_valid, one cycle, no stall
// config   cfg_index cfg_wdata                         cfg_we
//
// a write word leaves busy low and the next word may follow at once
// a compute word holds busy while the sequencer walks every i, j, k mac step
// and until the mac pipeline drains; a result word leaves after each last inner-dim step
// the single read port on each element memory sets the one-mac-per-cycle pace
// synchronous reset sets all dims to 8; element memories are not cleared
module matrix_multiply_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [mm_pkg::FIELD_W-1:0] in_row,
  input  logic [mm_pkg::FIELD_W-1:0] in_col,
  input  logic [mm_pkg::ELEM_W-1:0]  in_element,
  output logic                       out_valid,
  output logic [mm_pkg::FIELD_W-1:0] out_row,
  output logic [mm_pkg::FIELD_W-1:0] out_col,
  output logic [mm_pkg::ELEM_W-1:0]  out_sum,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]   cfg_wdata
);
  import mm_pkg::*;

  logic [DIM_W-1:0]  rows_a_r, inner_dim_r, cols_b_r;
  logic              accept, go, in_range, wr_a, wr_b;
  logic              running, pipe_busy;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0] rd_data_a, rd_data_b;
  mm_tag_t           tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy     = running || pipe_busy;
  assign accept   = start && !busy;
  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_a     = accept && in_range && (in_mode == MODE_WR_A);
  assign wr_b     = accept && in_range && (in_mode == MODE_WR_B);
  assign go       = accept && (in_mode == MODE_COMPUTE);

  mm_store u_store (
    .clk       (clk),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .wr_addr   (mm_addr(in_row, in_col)),
    .wr_data   (in_element),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .tag       (tag),
    .running   (running)
  );

  mm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag),
    .a_data    (rd_data_a),
    .b_data    (rd_data_b),
    .pipe_busy (pipe_busy),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_sum   (out_sum),
    .out_last  (out_last)
  );

`ifndef SYNTH
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy) else $error("compute word did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result word right after the last one");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !out_valid) |=> !out_valid)
    else $error("result word with nothing in flight");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !running)
    else $error("last word while the sequencer still runs");
`endif

endmodule

@@ tb/sv/mm_checker.sv @@
// checker for the matrix multiply core: predicts every result word and compares
`timescale 1ns / 100ps

module mm_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [mm_pkg::FIELD_W-1:0] in_row,
  input  logic [mm_pkg::FIELD_W-1:0] in_col,
  input  logic [mm_pkg::ELEM_W-1:0]  in_element,
  input  logic                       out_valid,
  input  logic [mm_pkg::FIELD_W-1:0] out_row,
  input  logic [mm_pkg::FIELD_W-1:0] out_col,
  input  logic [mm_pkg::ELEM_W-1:0]  out_sum,
  input  logic                       out_last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]   cfg_wdata,
  output int                         errors,
  output int                         pending,
  output int                         results_seen
);
  import mm_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [ELEM_W-1:0]  sum;
    logic               last;
  } c_elem_t;

  c_elem_t           c_elems_due[$];
  logic [ELEM_W-1:0] a_mem[MAX_DIM*MAX_DIM];
  logic [ELEM_W-1:0] b_mem[MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]  rows_reg;
  logic [DIM_W-1:0]  inner_reg;
  logic [DIM_W-1:0]  cols_reg;

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic int unsigned used_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > DIM_CAP) return DIM_CAP;
    return int'(v);
  endfunction

  // exact q32.32 dot product, rounded half up to q16.16 and clamped
  function automatic logic [ELEM_W-1:0] dot_q16(input int unsigned i, input int unsigned j,
                                                input int unsigned nk);
    logic signed [127:0] acc;
    logic signed [127:0] rnd;
    logic signed [63:0]  ea;
    logic signed [63:0]  eb;
    acc = '0;
    for (int unsigned k = 0; k < nk; k++) begin
      ea  = $signed(a_mem[i*MAX_DIM + k]);
      eb  = $signed(b_mem[k*MAX_DIM + j]);
      acc = acc + ea * eb;
    end
    rnd = (acc + 128'sd32768) >>> 16;
    if (rnd > 128'sd2147483647) return 32'h7fff_ffff;
    if (rnd < -128'sd2147483648) return 32'h8000_0000;
    return rnd[ELEM_W-1:0];
  endfunction

  task automatic queue_product();
    int unsigned nr;
    int unsigned nk;
    int unsigned nc;
    c_elem_t     w;
    nr = used_dim(rows_reg);
    nk = used_dim(inner_reg);
    nc = used_dim(cols_reg);
    for (int unsigned i = 0; i < nr; i++) begin
      for (int unsigned j = 0; j < nc; j++) begin
        w.row  = FIELD_W'(i);
        w.col  = FIELD_W'(j);
        w.sum  = dot_q16(i, j, nk);
        w.last = (i + 1 == nr) && (j + 1 == nc);
        c_elems_due.push_back(w);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [ELEM_W-1:0] want,
                               input logic [ELEM_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    c_elem_t want;
    if (!rst_n) begin
      rows_reg  = DIM_W'(8);
      inner_reg = DIM_W'(8);
      cols_reg  = DIM_W'(8);
      c_elems_due.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (c_elems_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got row %0d col %0d sum %h",
                   $time, out_row, out_col, out_sum);
        end else begin
          want = c_elems_due.pop_front();
          compare_field("out_row", ELEM_W'(want.row), ELEM_W'(out_row));
          compare_field("out_col", ELEM_W'(want.col), ELEM_W'(out_col));
          compare_field("out_sum", want.sum, out_sum);
          compare_field("out_last", ELEM_W'(want.last), ELEM_W'(out_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_A:    rows_reg  = cfg_wdata;
          CFG_INNER_DIM: inner_reg = cfg_wdata;
          CFG_COLS_B:    cols_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_mode)
          MODE_WR_A:    a_mem[int'(in_row)*MAX_DIM + int'(in_col)] = in_element;
          MODE_WR_B:    b_mem[int'(in_row)*MAX_DIM + int'(in_col)] = in_element;
          MODE_COMPUTE: queue_product();
          default: ;
        endcase
      end
    end
    pending = c_elems_due.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top for the matrix multiply core: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
  import mm_pkg::*;

  localparam int CYCLE_LIMIT  = 1200000;
  localparam int RANDOM_WORDS = 360;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic [FIELD_W-1:0] in_row;
  logic [FIELD_W-1:0] in_col;
  logic [ELEM_W-1:0]  in_element;
  logic               out_valid;
  logic [FIELD_W-1:0] out_row;
  logic [FIELD_W-1:0] out_col;
  logic [ELEM_W-1:0]  out_sum;
  logic               out_last;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [DIM_W-1:0]   cfg_wdata;

  int errors;
  int pending;
  int results_seen;

  bit [MAX_DIM*MAX_DIM-1:0] a_loaded;
  bit [MAX_DIM*MAX_DIM-1:0] b_loaded;
  int unsigned rows_used;
  int unsigned inner_used;
  int unsigned cols_used;
  int gap_max;
  int words_sent;
  int products;
  int reg_writes;

  matrix_multiply_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_element (in_element),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_sum    (out_sum),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mm_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_element   (in_element),
    .out_valid    (out_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_sum      (out_sum),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("cycle limit of %0d reached with %0d result words outstanding",
             CYCLE_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [ELEM_W-1:0] pick_element();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 7))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hffff_ffff;
          4:       v = 32'h0001_0000;
          5:       v = 32'hffff_0000;
          6:       v = 32'h0000_0001;
          default: v = 32'h0000_8000;
        endcase
      end
      1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom;
        v = {{12{v[19]}}, v[19:0]};
      end
      6: begin
        // single bit values can make exact half-way products
        v = 32'h1 << $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = {($urandom_range(0, 1) == 1) ? 2'b10 : 2'b01, 30'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return DIM_W'(0);
      1:       return DIM_W'(8);
      2:       return DIM_W'($urandom_range(9, 15));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [1:0] mode, input logic [FIELD_W-1:0] r,
                           input logic [FIELD_W-1:0] c, input logic [ELEM_W-1:0] e);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_mode    = mode;
    in_row     = r;
    in_col     = c;
    in_element = e;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (mode == MODE_WR_A) a_loaded[int'(r)*MAX_DIM + int'(c)] = 1'b1;
    if (mode == MODE_WR_B) b_loaded[int'(r)*MAX_DIM + int'(c)] = 1'b1;
    if (mode == MODE_COMPUTE) products++;
    if (mode != MODE_UNUSED) words_sent++;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    int unsigned eff;
    eff = (val == '0) ? 1 : ((int'(val) > DIM_CAP) ? DIM_CAP : int'(val));
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      CFG_ROWS_A:    rows_used  = eff;
      CFG_INNER_DIM: inner_used = eff;
      CFG_COLS_B:    cols_used  = eff;
      default: ;
    endcase
  endtask

  // loads any element the product reads that has never been written, then computes
  task automatic fill_and_compute();
    for (int unsigned i = 0; i < rows_used; i++)
      for (int unsigned k = 0; k < inner_used; k++)
        if (!a_loaded[i*MAX_DIM + k])
          send_word(MODE_WR_A, FIELD_W'(i), FIELD_W'(k), pick_element());
    for (int unsigned k = 0; k < inner_used; k++)
      for (int unsigned j = 0; j < cols_used; j++)
        if (!b_loaded[k*MAX_DIM + j])
          send_word(MODE_WR_B, FIELD_W'(k), FIELD_W'(j), pick_element());
    send_word(MODE_COMPUTE, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    int base;
    int nwr;
    bit first_phase;
    logic [1:0] wmode;
    logic [FIELD_W-1:0] wr;
    logic [FIELD_W-1:0] wc;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_mode    = MODE_WR_A;
    in_row     = '0;
    in_col     = '0;
    in_element = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ROWS_A;
    cfg_wdata  = '0;
    a_loaded   = '0;
    b_loaded   = '0;
    rows_used  = 8;
    inner_used = 8;
    cols_used  = 8;
    gap_max    = 3;
    words_sent = 0;
    products   = 0;
    reg_writes = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: one by one products at the value extremes
    set_reg(CFG_ROWS_A, DIM_W'(1));
    set_reg(CFG_INNER_DIM, DIM_W'(1));
    set_reg(CFG_COLS_B, DIM_W'(1));
    set_reg(CFG_SPARE, DIM_W'(5));
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_word(MODE_WR_B, 3'd0, 3'd0, 32'h7fff_ffff);
    send_word(MODE_COMPUTE, 3'd0, 3'd0, 32'h0);
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    send_word(MODE_COMPUTE, 3'd0, 3'd0, 32'h0);
    // half-way ties, one positive and one negative
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'h0000_0001);
    send_word(MODE_WR_B, 3'd0, 3'd0, 32'h0000_8000);
    send_word(MODE_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'hffff_ffff);
    send_word(MODE_COMPUTE, 3'd5, 3'd2, 32'h1234_5678);
    // unused mode and writes outside the current dimensions, then two more one by one products
    send_word(MODE_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
    send_word(MODE_WR_A, 3'd7, 3'd7, 32'hffff_ffff);
    send_word(MODE_WR_B, 3'd7, 3'd7, 32'h0000_0000);
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'h0001_0000);
    send_word(MODE_WR_B, 3'd0, 3'd0, 32'h8000_0000);
    send_word(MODE_COMPUTE, 3'd7, 3'd0, 32'h8000_0000);
    send_word(MODE_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    send_word(MODE_COMPUTE, 3'd0, 3'd7, 32'h7fff_ffff);

    base        = words_sent;
    first_phase = 1'b1;
    while (words_sent - base < RANDOM_WORDS) begin
      settle();
      if (first_phase || $urandom_range(0, 3) != 0) set_reg(CFG_ROWS_A, pick_dim());
      if (first_phase || $urandom_range(0, 3) != 0) set_reg(CFG_INNER_DIM, pick_dim());
      if (first_phase || $urandom_range(0, 3) != 0) set_reg(CFG_COLS_B, pick_dim());
      if ($urandom_range(0, 7) == 0) set_reg(CFG_SPARE, DIM_W'($urandom));
      first_phase = 1'b0;
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      nwr = $urandom_range(0, 12);
      repeat (nwr) begin
        wmode = ($urandom_range(0, 1) == 1) ? MODE_WR_B : MODE_WR_A;
        case ($urandom_range(0, 9))
          0: send_word(MODE_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
          1: send_word(wmode, FIELD_W'($urandom), FIELD_W'($urandom), pick_element());
          default: begin
            if (wmode == MODE_WR_A) begin
              wr = FIELD_W'($urandom_range(0, rows_used - 1));
              wc = FIELD_W'($urandom_range(0, inner_used - 1));
            end else begin
              wr = FIELD_W'($urandom_range(0, inner_used - 1));
              wc = FIELD_W'($urandom_range(0, cols_used - 1));
            end
            send_word(wmode, wr, wc, pick_element());
          end
        endcase
      end
      repeat ($urandom_range(1, 2)) fill_and_compute();
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d input words, %0d products and %0d register writes", words_sent,
             products, reg_writes);
    $display("checked %0d result words over dimensions 1 to 8, with zero and oversize settings",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ matrix_multiply_core.f @@
hw/rtl/mm_pkg.sv
hw/rtl/mm_store.sv
hw/rtl/mm_seq.sv
hw/rtl/mm_mac.sv
hw/rtl/matrix_multiply_core.sv
tb/sv/mm_checker.sv
tb/sv/tb_top.sv
